// ===== src/scfl_pkg.sv =====
// scfl_pkg: shared types and constants of the size class free list allocator
// holds field widths, operation and status codes, sequencer states and
// the header store control group; no dependencies

package scfl_pkg;

  // default sizing of the pool, used as top level parameter defaults
  localparam int unsigned NUM_PAGES_DEF   = 64;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned NUM_CLASSES_DEF = 64;

  // fixed geometry of the chunk format
  localparam int unsigned UNIT_SHIFT = 5;
  localparam int unsigned HDR_BYTES  = 8;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BYTES_W  = 12;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned ADDR_W   = 18;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USABLE_W = 11;

  // header unit index taken from a byte address
  localparam int unsigned RAW_W   = ADDR_W - UNIT_SHIFT;
  // chunk size from a 12 bit request tops out at 129 units
  localparam int unsigned CSIZE_W = 13;
  localparam int unsigned STEP_W  = CSIZE_W - UNIT_SHIFT;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_PAGE     = 2'd1,
    STAT_NOT_HANDLED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACLS,
    S_AHEAD,
    S_CARVE,
    S_IRD,
    S_APOP,
    S_PGCHK,
    S_IMOD,
    S_FREAD,
    S_FPUSH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic we_word;
    logic we_tag;
  } hdr_ctl_t;

endpackage

// ===== src/scfl_head_tbl.sv =====
// scfl_head_tbl: per class free list heads, single port with registered read
// entries not yet written since reset read as the empty list (zero)
// no package dependencies

module scfl_head_tbl #(
  parameter int unsigned NUM_CLASSES = 64,
  parameter int unsigned HEAD_W      = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [$clog2(NUM_CLASSES)-1:0] addr_i,
  input  logic [HEAD_W-1:0]              wdata_i,
  output logic [HEAD_W-1:0]              rd_data_o
);

  logic [HEAD_W-1:0]      head_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_q;
  logic [HEAD_W-1:0]      rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      head_mem[addr_i] <= wdata_i;
    end
    rd_q <= vld_q[addr_i] ? head_mem[addr_i] : '0;
  end

  assign rd_data_o = rd_q;

endmodule

// ===== src/scfl_hdr_ram.sv =====
// scfl_hdr_ram: chunk header store, one entry per 32 byte unit of the pool
// word part (size or link) and tag part written separately; registered read
// depends on scfl_pkg for the tag width and control group

module scfl_hdr_ram #(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned WORD_W = 14
) (
  input  logic                        clk_i,
  input  scfl_pkg::hdr_ctl_t          ctl_i,
  input  logic [$clog2(DEPTH)-1:0]    addr_i,
  input  logic [WORD_W-1:0]           wword_i,
  input  logic [scfl_pkg::TAG_W-1:0]  wtag_i,
  output logic [WORD_W-1:0]           rd_word_o
);

  import scfl_pkg::*;

  logic [WORD_W-1:0] word_mem [DEPTH];
  logic [TAG_W-1:0]  tag_mem  [DEPTH];
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_word) begin
      word_mem[addr_i] <= wword_i;
    end
    rd_q <= word_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_tag) begin
      tag_mem[addr_i] <= wtag_i;
    end
  end

  assign rd_word_o = rd_q;

endmodule

// ===== src/size_class_free_list_allocator.sv =====
// size_class_free_list_allocator: segregated free list allocator over a page pool
// sequencer with one shared adder, class head table and header store
// depends on scfl_pkg, scfl_head_tbl and scfl_hdr_ram
//
// usage
// - input channel (in_valid_i / in_stall_o) takes one request word: allocate,
//   free or query; output channel (out_valid_o / out_stall_i) returns one
//   status word per request, in order
// - allocate from a class with a free chunk steps through class lookup, head read
//   and pop; query through page check, index reduction and header read; free adds a push
// - allocate from an empty class links a fresh page first, one chunk per cycle
//   (PAGE_BYTES / chunk size, up to 128 at 4 KiB pages), then reads and pops the first chunk
// - free and query reduce the header index modulo the store depth with the
//   shared adder, one subtraction a cycle; none at the default sizes
// - in_stall_o is high while a request is in flight; one result word may sit
//   in the output register while the next request is taken
// - when the receiver stalls, the result holds and a finished request waits
//   until the output register frees
// - reset empties every class list and returns all pages; no clearing pass,
//   the block is ready as soon as reset is released
// - PAGE_BYTES must be a power of two; the block itself does not enforce it

module size_class_free_list_allocator #(
  parameter int unsigned NUM_PAGES   = scfl_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES  = scfl_pkg::PAGE_BYTES_DEF,
  parameter int unsigned NUM_CLASSES = scfl_pkg::NUM_CLASSES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [scfl_pkg::KIND_W-1:0]   kind_i,
  input  logic [scfl_pkg::BYTES_W-1:0]  byte_count_i,
  input  logic [scfl_pkg::TAG_W-1:0]    owner_tag_i,
  input  logic [scfl_pkg::ADDR_W-1:0]   block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [scfl_pkg::STATUS_W-1:0] status_o,
  output logic [scfl_pkg::ADDR_W-1:0]   result_address_o,
  output logic [scfl_pkg::USABLE_W-1:0] usable_bytes_o
);

  import scfl_pkg::*;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_UNITS = PAGE_BYTES >> UNIT_SHIFT;
  localparam int unsigned HDR_DEPTH  = NUM_PAGES * PAGE_UNITS;
  localparam int unsigned IDX_W      = $clog2(HDR_DEPTH);
  localparam int unsigned HEAD_W     = $clog2(HDR_DEPTH + 1);
  localparam int unsigned WORD_W     = (HEAD_W > CSIZE_W) ? HEAD_W : CSIZE_W;
  localparam int unsigned CLS_W      = $clog2(NUM_CLASSES);
  localparam int unsigned PG_W       = $clog2(NUM_PAGES + 1);
  localparam int unsigned REM_W      = $clog2(PAGE_UNITS + 1);
  localparam int unsigned ALU_W      = (ADDR_W > IDX_W + UNIT_SHIFT) ? ADDR_W
                                                                     : IDX_W + UNIT_SHIFT;
  localparam int unsigned LARGE_LIM  = PAGE_BYTES / 2 - HDR_BYTES;

  state_e                state_q, state_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [BYTES_W-1:0]    bytes_q, bytes_d;
  logic [TAG_W-1:0]      tag_q, tag_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [RAW_W-1:0]      raw_q, raw_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CLS_W-1:0]      cls_q, cls_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [HEAD_W-1:0]     pos_q, pos_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [PG_W-1:0]       pages_used_q, pages_used_d;
  logic [HEAD_W-1:0]     page_base_q, page_base_d;
  status_e               res_st_q, res_st_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic [USABLE_W-1:0]   res_use_q, res_use_d;
  logic                  out_valid_q, out_valid_d;
  status_e               out_st_q, out_st_d;
  logic [ADDR_W-1:0]     out_addr_q, out_addr_d;
  logic [USABLE_W-1:0]   out_use_q, out_use_d;

  // shared adder
  logic [ALU_W-1:0]      alu_a, alu_b, alu_y;
  logic                  alu_sub, alu_borrow;
  logic [ALU_W:0]        alu_full;

  logic                  head_we;
  logic [CLS_W-1:0]      head_addr;
  logic [HEAD_W-1:0]     head_wdata, head_rd;
  hdr_ctl_t              hdr_ctl;
  logic [IDX_W-1:0]      hdr_addr;
  logic [WORD_W-1:0]     hdr_wword, hdr_rd;

  logic                  fin, out_free, more;
  status_e               fin_st;
  logic [ADDR_W-1:0]     fin_addr;
  logic [USABLE_W-1:0]   fin_use;
  logic [ALU_W-1:0]      cls_raw;
  logic [CSIZE_W-1:0]    csize;

  assign alu_full   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_y      = alu_full[ALU_W-1:0];
  assign alu_borrow = alu_full[ALU_W];

  assign cls_raw  = alu_y >> UNIT_SHIFT;
  assign csize    = {step_q, {UNIT_SHIFT{1'b0}}};
  assign more     = 32'(rem_q) >= 32'(step_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    bytes_d      = bytes_q;
    tag_d        = tag_q;
    addr_d       = addr_q;
    raw_d        = raw_q;
    idx_d        = idx_q;
    cls_d        = cls_q;
    step_d       = step_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    pages_used_d = pages_used_q;
    page_base_d  = page_base_q;
    res_st_d     = res_st_q;
    res_addr_d   = res_addr_q;
    res_use_d    = res_use_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_st_d     = out_st_q;
    out_addr_d   = out_addr_q;
    out_use_d    = out_use_q;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;
    head_we      = 1'b0;
    head_addr    = cls_q;
    head_wdata   = '0;
    hdr_ctl      = '0;
    hdr_addr     = idx_q;
    hdr_wword    = '0;
    fin          = 1'b0;
    fin_st       = STAT_OK;
    fin_addr     = '0;
    fin_use      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          bytes_d = byte_count_i;
          tag_d   = owner_tag_i;
          addr_d  = block_address_i;
          unique case (kind_i)
            KIND_ALLOC: state_d = S_ACLS;
            KIND_FREE,
            KIND_QUERY: state_d = S_PGCHK;
            default: begin
              fin    = 1'b1;
              fin_st = STAT_NOT_HANDLED;
            end
          endcase
        end
      end

      S_ACLS: begin
        alu_a     = ALU_W'(bytes_q);
        alu_b     = ALU_W'(HDR_BYTES - 1);
        head_addr = CLS_W'(cls_raw);
        if (32'(bytes_q) > LARGE_LIM || cls_raw >= ALU_W'(NUM_CLASSES)) begin
          fin    = 1'b1;
          fin_st = STAT_NOT_HANDLED;
        end else begin
          cls_d   = CLS_W'(cls_raw);
          step_d  = STEP_W'(cls_raw + ALU_W'(1));
          state_d = S_AHEAD;
        end
      end

      S_AHEAD: begin
        alu_a   = ALU_W'(head_rd);
        alu_b   = ALU_W'(1);
        alu_sub = 1'b1;
        if (head_rd != '0) begin
          idx_d    = IDX_W'(alu_y);
          hdr_addr = IDX_W'(alu_y);
          state_d  = S_APOP;
        end else if (pages_used_q >= PG_W'(NUM_PAGES)) begin
          fin    = 1'b1;
          fin_st = STAT_NO_PAGE;
        end else begin
          pos_d   = page_base_q;
          rem_d   = REM_W'(PAGE_UNITS) - REM_W'(step_q);
          state_d = S_CARVE;
        end
      end

      // one chunk per cycle, each word links to the next chunk of the page, the last word is zero
      S_CARVE: begin
        alu_a           = ALU_W'(pos_q);
        alu_b           = ALU_W'(step_q);
        hdr_addr        = IDX_W'(pos_q);
        hdr_ctl.we_word = 1'b1;
        hdr_wword       = more ? WORD_W'(HEAD_W'(alu_y) + HEAD_W'(1)) : '0;
        pos_d           = HEAD_W'(alu_y);
        rem_d           = rem_q - REM_W'(step_q);
        if (!more) begin
          pages_used_d = pages_used_q + PG_W'(1);
          page_base_d  = page_base_q + HEAD_W'(PAGE_UNITS);
          idx_d        = IDX_W'(page_base_q);
          state_d      = S_IRD;
        end
      end

      S_IRD: begin
        state_d = S_APOP;
      end

      S_APOP: begin
        alu_a          = ALU_W'(idx_q) << UNIT_SHIFT;
        alu_b          = ALU_W'(HDR_BYTES);
        head_we        = 1'b1;
        head_wdata     = HEAD_W'(hdr_rd);
        hdr_ctl        = '{we_word: 1'b1, we_tag: 1'b1};
        hdr_wword      = WORD_W'(csize);
        fin            = 1'b1;
        fin_addr       = alu_y[ADDR_W-1:0];
        fin_use        = USABLE_W'(csize - CSIZE_W'(HDR_BYTES));
      end

      S_PGCHK: begin
        alu_a   = ALU_W'(addr_q);
        alu_b   = ALU_W'(HDR_BYTES);
        alu_sub = 1'b1;
        if (addr_q[PAGE_SHIFT-1:0] == '0) begin
          fin    = 1'b1;
          fin_st = STAT_NOT_HANDLED;
        end else begin
          raw_d   = alu_y[ADDR_W-1:UNIT_SHIFT];
          state_d = S_IMOD;
        end
      end

      // index wraps modulo the store depth
      S_IMOD: begin
        alu_a    = ALU_W'(raw_q);
        alu_b    = ALU_W'(HDR_DEPTH);
        alu_sub  = 1'b1;
        hdr_addr = IDX_W'(raw_q);
        if (!alu_borrow) begin
          raw_d = RAW_W'(alu_y);
        end else begin
          idx_d   = IDX_W'(raw_q);
          state_d = S_FREAD;
        end
      end

      S_FREAD: begin
        alu_a   = ALU_W'(hdr_rd);
        alu_sub = 1'b1;
        if (kind_q == KIND_QUERY) begin
          alu_b   = ALU_W'(HDR_BYTES);
          fin     = 1'b1;
          fin_use = alu_y[USABLE_W-1:0];
        end else begin
          alu_b     = ALU_W'(1);
          head_addr = CLS_W'(cls_raw);
          // a zero word or an out of range class leaves the lists alone
          if (hdr_rd != '0 && cls_raw < ALU_W'(NUM_CLASSES)) begin
            cls_d   = CLS_W'(cls_raw);
            state_d = S_FPUSH;
          end else begin
            fin = 1'b1;
          end
        end
      end

      S_FPUSH: begin
        alu_a           = ALU_W'(idx_q);
        alu_b           = ALU_W'(1);
        head_we         = 1'b1;
        head_wdata      = HEAD_W'(alu_y);
        hdr_ctl.we_word = 1'b1;
        hdr_wword       = WORD_W'(head_rd);
        fin             = 1'b1;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_addr_d  = res_addr_q;
          out_use_d   = res_use_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // finished word goes straight out when the output register is free
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_st_d    = fin_st;
        out_addr_d  = fin_addr;
        out_use_d   = fin_use;
        state_d     = S_IDLE;
      end else begin
        res_st_d   = fin_st;
        res_addr_d = fin_addr;
        res_use_d  = fin_use;
        state_d    = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pages_used_q <= '0;
      page_base_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pages_used_q <= pages_used_d;
      page_base_q  <= page_base_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    bytes_q    <= bytes_d;
    tag_q      <= tag_d;
    addr_q     <= addr_d;
    raw_q      <= raw_d;
    idx_q      <= idx_d;
    cls_q      <= cls_d;
    step_q     <= step_d;
    pos_q      <= pos_d;
    rem_q      <= rem_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_use_q  <= res_use_d;
    out_st_q   <= out_st_d;
    out_addr_q <= out_addr_d;
    out_use_q  <= out_use_d;
  end

  scfl_head_tbl #(
    .NUM_CLASSES (NUM_CLASSES),
    .HEAD_W      (HEAD_W)
  ) u_head_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (head_we),
    .addr_i    (head_addr),
    .wdata_i   (head_wdata),
    .rd_data_o (head_rd)
  );

  scfl_hdr_ram #(
    .DEPTH  (HDR_DEPTH),
    .WORD_W (WORD_W)
  ) u_hdr_ram (
    .clk_i     (clk_i),
    .ctl_i     (hdr_ctl),
    .addr_i    (hdr_addr),
    .wword_i   (hdr_wword),
    .wtag_i    (tag_q),
    .rd_word_o (hdr_rd)
  );

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign result_address_o = out_addr_q;
  assign usable_bytes_o   = out_use_q;

`ifndef SYNTHESIS
  a_chunk_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_address_o != '0)
      |-> (result_address_o[UNIT_SHIFT-1:0] == UNIT_SHIFT'(HDR_BYTES)))
    else $error("allocated address not a chunk start plus header");

  a_pages_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pages_used_q) <= NUM_PAGES)
    else $error("page count beyond pool");

  a_base_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(page_base_q) == 32'(pages_used_q) * PAGE_UNITS)
    else $error("page base out of step with page count");

  a_carve_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CARVE) |-> (32'(pos_q) < HDR_DEPTH))
    else $error("page linking ran past the header store");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK)
      |-> (result_address_o == '0 && usable_bytes_o == '0))
    else $error("rejected request returned non-zero fields");
`endif

endmodule
